// ----- hdl/sacr_pkg.sv -----
// Shared types and constants of the set-associative cache tag store.
`timescale 1ns / 1ps
package sacr_pkg;

   localparam int ADDR_W      = 32;
   localparam int TAG_W       = 32;
   localparam int COUNT_W     = 32;
   localparam int OFFSET_W    = 3;
   localparam int INDEX_W     = 3;
   localparam int WAYS_W      = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;
   localparam int SHIFT_W     = 4;
   // Widest set index that the index_bits field can describe.
   localparam int IX_W        = (1 << INDEX_W) - 1;
   localparam int IX_RANGE    = 1 << IX_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_BITS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_BITS  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAYS_IN_USE = 2'd2;

   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 3'd4;
   localparam logic [INDEX_W-1:0]  INDEX_RESET  = 3'd4;
   localparam logic [WAYS_W-1:0]   WAYS_RESET   = 4'd8;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef struct packed {
      logic valid;
      logic used;
      logic dirty;
   } line_state_type;

   typedef struct packed {
      logic match;
      logic candidate;
   } way_eval_type;

endpackage

// ----- hdl/sacr_if.sv -----
// Valid/ready channel interfaces for access requests and their results.
`timescale 1ns / 1ps
interface sacr_req_if;
   logic                         valid;
   logic                         ready;
   logic                         operation;
   logic [sacr_pkg::ADDR_W-1:0]  address;

   modport source (output valid, output operation, output address, input ready);
   modport sink (input valid, input operation, input address, output ready);
endinterface

interface sacr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         hit;
   logic                         filled_invalid;
   logic                         evicted;
   logic [sacr_pkg::ADDR_W-1:0]  evicted_address;
   logic                         evicted_dirty;
   logic [sacr_pkg::COUNT_W-1:0] hit_count;
   logic [sacr_pkg::COUNT_W-1:0] miss_count;

   modport source (output valid, output hit, output filled_invalid, output evicted,
                   output evicted_address, output evicted_dirty, output hit_count,
                   output miss_count, input ready);
   modport sink (input valid, input hit, input filled_invalid, input evicted,
                 input evicted_address, input evicted_dirty, input hit_count,
                 input miss_count, output ready);
endinterface

// ----- hdl/sacr_line_store.sv -----
// Tag and line state memories, one write port and one registered read port each.
`timescale 1ns / 1ps
module sacr_line_store #(
   parameter int DEPTH      = 512,
   parameter int ADDR_WIDTH = 9
) (
   input  logic                         clock,
   input  logic [ADDR_WIDTH-1:0]        rd_addr,
   output logic [sacr_pkg::TAG_W-1:0]   rd_tag,
   output sacr_pkg::line_state_type     rd_state,
   input  logic                         wr_tag_en,
   input  logic                         wr_state_en,
   input  logic [ADDR_WIDTH-1:0]        wr_addr,
   input  logic [sacr_pkg::TAG_W-1:0]   wr_tag,
   input  sacr_pkg::line_state_type     wr_state
);
   import sacr_pkg::*;

   logic [TAG_W-1:0] tag_mem [DEPTH];
   line_state_type   state_mem [DEPTH];
   logic [TAG_W-1:0] rd_tag_ff;
   line_state_type   rd_state_ff;

   always_ff @(posedge clock) begin
      if (wr_tag_en) begin
         tag_mem[wr_addr] <= wr_tag;
      end
      if (wr_state_en) begin
         state_mem[wr_addr] <= wr_state;
      end
      rd_tag_ff   <= tag_mem[rd_addr];
      rd_state_ff <= state_mem[rd_addr];
   end

   assign rd_tag   = rd_tag_ff;
   assign rd_state = rd_state_ff;

endmodule

// ----- hdl/sacr_way_unit.sv -----
// Shared per-way compare unit: tag match and replacement candidacy of one way.
`timescale 1ns / 1ps
module sacr_way_unit (
   input  sacr_pkg::line_state_type    line_state,
   input  logic [sacr_pkg::TAG_W-1:0]  stored_tag,
   input  logic [sacr_pkg::TAG_W-1:0]  lookup_tag,
   output sacr_pkg::way_eval_type      result
);
   import sacr_pkg::*;

   logic tag_equal;

   assign tag_equal        = (stored_tag == lookup_tag);
   assign result.match     = line_state.valid && tag_equal;
   // A way whose use bit is clear, or that holds nothing, can take the new line.
   assign result.candidate = !(line_state.valid && line_state.used);

endmodule

// ----- hdl/set_assoc_cache_clock_replace_unit.sv -----
// Set-associative cache tag store with use-bit (clock) replacement, top level.
//
// An access (operation, address) arrives on req_chan and one result leaves on
// rsp_chan; both are valid/ready channels and a transfer happens on a clock edge
// with valid and ready high. The csr port writes offset_bits, index_bits and
// ways_in_use; the user must write it only while no access is in flight, as
// the block does not enforce this.
//
// Each access is handled one at a time by a small sequencer around one compare
// unit and one read port of the line memories. With W effective ways the search
// reads one way per cycle; a hit then writes its way's state, and a miss writes
// each way up to the victim, or every way when none was a candidate. The result
// register is loaded last, and the next access is taken only once it is loaded.
// The single read and write ports of the memories are why ways go one at a time.
//
// After reset the block clears every entry of the line state memory, one entry
// per cycle, with req_chan.ready low; csr writes are taken then.
// The result register decouples the sides: a new access may be accepted and
// searched while a result waits, and it is held in its final cycle until the
// receiver takes the waiting result.
`timescale 1ns / 1ps
module set_assoc_cache_clock_replace_unit #(
   parameter int MAX_SETS  = 64,
   parameter int MAX_WAYS  = 8,
   parameter int ADDR_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   sacr_req_if.sink                           req_chan,
   sacr_rsp_if.source                         rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [sacr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sacr_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import sacr_pkg::*;

   localparam int NUM_LINES = MAX_SETS * MAX_WAYS;
   localparam int LINE_W    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
   localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int CNT_W     = $clog2(MAX_WAYS + 1);
   localparam logic [ADDR_W-1:0] ADDR_MASK =
      (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // Configuration registers.
   logic [OFFSET_W-1:0] cfg_offset_bits_ff;
   logic [INDEX_W-1:0]  cfg_index_bits_ff;
   logic [WAYS_W-1:0]   cfg_ways_ff;

   // Sequencer and per-access registers.
   state_type           state_ff;
   logic [LINE_W-1:0]   clear_idx_ff;
   logic                op_ff;
   logic [TAG_W-1:0]    tag_ff;
   logic [SET_W-1:0]    set_ff;
   logic [LINE_W-1:0]   base_ff;
   logic [CNT_W-1:0]    ways_ff;
   logic [CNT_W-1:0]    step_ff;
   logic [WAY_W-1:0]    upd_way_ff;
   logic                hit_ff;
   logic [WAY_W-1:0]    hit_way_ff;
   logic                found_ff;
   logic [WAY_W-1:0]    victim_way_ff;
   logic                victim_valid_ff;
   logic [TAG_W-1:0]    victim_tag_ff;
   logic                victim_dirty_ff;
   logic [MAX_WAYS-1:0] dirty_vec_ff;
   logic [COUNT_W-1:0]  hits_ff;
   logic [COUNT_W-1:0]  misses_ff;

   // Result register.
   logic                rsp_valid_ff;
   logic                rsp_hit_ff;
   logic                rsp_filled_ff;
   logic                rsp_evicted_ff;
   logic [ADDR_W-1:0]   rsp_ev_addr_ff;
   logic                rsp_ev_dirty_ff;
   logic [COUNT_W-1:0]  rsp_hits_ff;
   logic [COUNT_W-1:0]  rsp_misses_ff;

   // Decode of the incoming access.
   logic [ADDR_W-1:0]   addr_masked;
   logic [IX_W-1:0]     ix_mask;
   logic [IX_W-1:0]     req_ix;
   logic [SHIFT_W-1:0]  tag_shift;
   logic [TAG_W-1:0]    req_tag;
   logic [SET_W-1:0]    req_set;
   logic [CNT_W-1:0]    eff_ways;
   logic [SET_W-1:0]    set_lut [IX_RANGE];

   // Memory and compare unit hookup.
   logic [LINE_W-1:0]   rd_addr;
   logic [TAG_W-1:0]    rd_tag;
   line_state_type      rd_state;
   logic                wr_tag_en;
   logic                wr_state_en;
   logic [LINE_W-1:0]   wr_addr;
   line_state_type      wr_state;
   way_eval_type        way_eval;
   logic [WAY_W-1:0]    eval_way;
   logic                update_done;

   // Result values.
   logic [2*ADDR_W-1:0] ev_wide;
   logic                fill_evicts;
   logic [COUNT_W-1:0]  hits_next;
   logic [COUNT_W-1:0]  misses_next;
   logic                req_fire;
   logic                rsp_load;

   // The set number wraps at MAX_SETS; the table is fixed at elaboration.
   for (genvar g = 0; g < IX_RANGE; g++) begin : g_set_lut
      assign set_lut[g] = SET_W'(g % MAX_SETS);
   end

   assign addr_masked = req_chan.address & ADDR_MASK;
   assign ix_mask     = ~({IX_W{1'b1}} << cfg_index_bits_ff);
   assign req_ix      = IX_W'(addr_masked >> cfg_offset_bits_ff) & ix_mask;
   assign tag_shift   = SHIFT_W'(cfg_offset_bits_ff) + SHIFT_W'(cfg_index_bits_ff);
   assign req_tag     = addr_masked >> tag_shift;
   assign req_set     = set_lut[req_ix];

   always_comb begin
      if (cfg_ways_ff == '0) begin
         eff_ways = CNT_W'(1);
      end else if (int'(cfg_ways_ff) > MAX_WAYS) begin
         eff_ways = CNT_W'(MAX_WAYS);
      end else begin
         eff_ways = CNT_W'(cfg_ways_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_offset_bits_ff <= OFFSET_RESET;
         cfg_index_bits_ff  <= INDEX_RESET;
         cfg_ways_ff        <= WAYS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_OFFSET_BITS: cfg_offset_bits_ff <= csr_write_data[OFFSET_W-1:0];
            CSR_INDEX_BITS:  cfg_index_bits_ff  <= csr_write_data[INDEX_W-1:0];
            CSR_WAYS_IN_USE: cfg_ways_ff        <= csr_write_data[WAYS_W-1:0];
            default: ;
         endcase
      end
   end

   assign rd_addr  = base_ff + LINE_W'(step_ff[WAY_W-1:0]);
   assign eval_way = WAY_W'(step_ff - CNT_W'(1));

   sacr_line_store #(
      .DEPTH      (NUM_LINES),
      .ADDR_WIDTH (LINE_W)
   ) u_line_store (
      .clock       (clock),
      .rd_addr     (rd_addr),
      .rd_tag      (rd_tag),
      .rd_state    (rd_state),
      .wr_tag_en   (wr_tag_en),
      .wr_state_en (wr_state_en),
      .wr_addr     (wr_addr),
      .wr_tag      (tag_ff),
      .wr_state    (wr_state)
   );

   sacr_way_unit u_way_unit (
      .line_state (rd_state),
      .stored_tag (rd_tag),
      .lookup_tag (tag_ff),
      .result     (way_eval)
   );

   // Write side of the memories: clearing pass, hit update, or replacement sweep.
   always_comb begin
      wr_state_en = 1'b0;
      wr_tag_en   = 1'b0;
      wr_addr     = base_ff + LINE_W'(upd_way_ff);
      wr_state    = '0;
      case (state_ff)
         ST_CLEAR: begin
            wr_state_en = 1'b1;
            wr_addr     = clear_idx_ff;
         end
         ST_UPDATE: begin
            wr_state_en = 1'b1;
            if (hit_ff) begin
               wr_addr        = base_ff + LINE_W'(hit_way_ff);
               wr_state.valid = 1'b1;
               wr_state.used  = 1'b1;
               wr_state.dirty = dirty_vec_ff[hit_way_ff] | (op_ff == OP_WRITE);
            end else if (upd_way_ff == victim_way_ff) begin
               wr_tag_en      = 1'b1;
               wr_state.valid = 1'b1;
               wr_state.used  = 1'b1;
               wr_state.dirty = (op_ff == OP_WRITE);
            end else begin
               // Second chance: the way keeps its line but loses its use bit.
               wr_state.valid = 1'b1;
               wr_state.used  = 1'b0;
               wr_state.dirty = dirty_vec_ff[upd_way_ff];
            end
         end
         default: ;
      endcase
   end

   // Without a candidate in the search, every way is swept and way 0 is refilled.
   assign update_done = hit_ff ||
                        (found_ff ? (upd_way_ff == victim_way_ff)
                                  : (upd_way_ff == WAY_W'(ways_ff - CNT_W'(1))));

   assign fill_evicts = !hit_ff && victim_valid_ff;
   assign ev_wide     = ((2*ADDR_W)'(victim_tag_ff) << cfg_index_bits_ff |
                         (2*ADDR_W)'(set_ff)) << cfg_offset_bits_ff;
   assign hits_next   = (hit_ff && (hits_ff != '1)) ? hits_ff + COUNT_W'(1) : hits_ff;
   assign misses_next = (!hit_ff && (misses_ff != '1)) ? misses_ff + COUNT_W'(1) : misses_ff;
   assign req_fire    = req_chan.valid && req_chan.ready;
   assign rsp_load    = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_idx_ff <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         found_ff     <= 1'b0;
         step_ff      <= '0;
         upd_way_ff   <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clear_idx_ff <= clear_idx_ff + LINE_W'(1);
               if (clear_idx_ff == LINE_W'(NUM_LINES - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_fire) begin
                  op_ff    <= req_chan.operation;
                  tag_ff   <= req_tag;
                  set_ff   <= req_set;
                  base_ff  <= LINE_W'(int'(req_set) * MAX_WAYS);
                  ways_ff  <= eff_ways;
                  step_ff  <= '0;
                  hit_ff   <= 1'b0;
                  found_ff <= 1'b0;
                  state_ff <= ST_SEARCH;
               end
            end
            ST_SEARCH: begin
               // Way step - 1 is on the read port while way step is addressed.
               if (step_ff != '0) begin
                  dirty_vec_ff[eval_way] <= rd_state.dirty;
                  if (way_eval.match && !hit_ff) begin
                     hit_ff     <= 1'b1;
                     hit_way_ff <= eval_way;
                  end
                  if (eval_way == '0) begin
                     victim_way_ff   <= '0;
                     victim_valid_ff <= rd_state.valid;
                     victim_tag_ff   <= rd_tag;
                     victim_dirty_ff <= rd_state.dirty;
                     found_ff        <= way_eval.candidate;
                  end else if (!found_ff && way_eval.candidate) begin
                     victim_way_ff   <= eval_way;
                     victim_valid_ff <= rd_state.valid;
                     victim_tag_ff   <= rd_tag;
                     victim_dirty_ff <= rd_state.dirty;
                     found_ff        <= 1'b1;
                  end
               end
               if (step_ff == ways_ff) begin
                  upd_way_ff <= '0;
                  state_ff   <= ST_UPDATE;
               end else begin
                  step_ff <= step_ff + CNT_W'(1);
               end
            end
            ST_UPDATE: begin
               if (update_done) begin
                  state_ff <= ST_FINISH;
               end else begin
                  upd_way_ff <= upd_way_ff + WAY_W'(1);
               end
            end
            ST_FINISH: begin
               if (rsp_load) begin
                  rsp_hit_ff      <= hit_ff;
                  rsp_filled_ff   <= !hit_ff && !victim_valid_ff;
                  rsp_evicted_ff  <= fill_evicts;
                  rsp_ev_addr_ff  <= fill_evicts ? ev_wide[ADDR_W-1:0] : '0;
                  rsp_ev_dirty_ff <= fill_evicts && victim_dirty_ff;
                  rsp_hits_ff     <= hits_next;
                  rsp_misses_ff   <= misses_next;
                  hits_ff         <= hits_next;
                  misses_ff       <= misses_next;
                  state_ff        <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_chan.ready           = (state_ff == ST_IDLE);
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.hit             = rsp_hit_ff;
   assign rsp_chan.filled_invalid  = rsp_filled_ff;
   assign rsp_chan.evicted         = rsp_evicted_ff;
   assign rsp_chan.evicted_address = rsp_ev_addr_ff;
   assign rsp_chan.evicted_dirty   = rsp_ev_dirty_ff;
   assign rsp_chan.hit_count       = rsp_hits_ff;
   assign rsp_chan.miss_count      = rsp_misses_ff;

   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $countones({rsp_hit_ff, rsp_filled_ff, rsp_evicted_ff}) == 1)
      else $error("result does not report exactly one of hit, fill and eviction");

   a_no_evict_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_evicted_ff) |-> (rsp_ev_addr_ff == '0 && !rsp_ev_dirty_ff))
      else $error("eviction fields set on a result without eviction");

   a_no_write_in_search: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH || state_ff == ST_IDLE) |-> (!wr_state_en && !wr_tag_en))
      else $error("line memory written outside the clearing and update phases");

   a_counts_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (hits_ff >= $past(hits_ff) && misses_ff >= $past(misses_ff)))
      else $error("hit or miss count decreased");

endmodule
